FILE: sv/word_run_length_decoder_assert.svh
// Assertion macros used by the top level of the word run-length decoder RTL.
`ifndef WORD_RUN_LENGTH_DECODER_ASSERT_SVH
`define WORD_RUN_LENGTH_DECODER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define WRLD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define WRLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/wrld_pkg.sv
// Package with widths, codes and types of the word run-length decoder.
package wrld_pkg;

  localparam int WORD_W      = 16;
  localparam int COUNT_W     = 15;
  localparam int RAY_TOTAL_W = 24;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam int TOTAL_WIDTH_DEF = 24;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [WORD_W-1:0] SIGN16 = 16'h8000;
  localparam logic [WORD_W-1:0] MASK15 = 16'h7fff;

  localparam logic [WORD_W-1:0] EOR_CODE_RESET = 16'h0000;
  localparam logic [WORD_W-1:0] LRC_CODE_RESET = 16'hffff;

  // Register index, taken from paddr[2].
  localparam logic REG_EOR_CODE = 1'b0;
  localparam logic REG_LRC_CODE = 1'b1;

  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_ZERO    = 2'd1,
    KIND_RAY     = 2'd2
  } wrld_kind_e;

  // One decoded result waiting in the queue; value is the literal word,
  // the zero count or the ray total, depending on kind.
  typedef struct packed {
    wrld_kind_e             kind;
    logic [RAY_TOTAL_W-1:0] value;
  } wrld_entry_t;

  typedef struct packed {
    logic        push;
    wrld_entry_t entry;
  } wrld_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wrld_qstat_t;

  typedef struct packed {
    logic in_literal;
    logic left_zero;
  } wrld_front_stat_t;

endpackage

FILE: sv/wrld_if.sv
// Valid/ready channel interfaces for the decoder input and result streams.
interface wrld_in_if;
  import wrld_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] payload_word;
  logic              record_end;

  modport source (output valid, output payload_word, output record_end, input ready);
  modport sink (input valid, input payload_word, input record_end, output ready);
endinterface

interface wrld_out_if;
  import wrld_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [WORD_W-1:0]      data_word;
  logic [COUNT_W-1:0]     zero_count;
  logic [RAY_TOTAL_W-1:0] ray_total;

  modport source (output valid, output kind, output data_word, output zero_count,
                  output ray_total, input ready);
  modport sink (input valid, input kind, input data_word, input zero_count,
                input ray_total, output ready);
endinterface

FILE: sv/wrld_fifo.sv
// Short result queue between the decode front and the output back end.
module wrld_fifo #(
  parameter int QUEUE_DEPTH = wrld_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wrld_pkg::wrld_push_t push_i,
  input  logic                 pop_i,
  output wrld_pkg::wrld_entry_t head_o,
  output wrld_pkg::wrld_qstat_t stat_o
);
  import wrld_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  wrld_entry_t      mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i.push && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

FILE: sv/wrld_front.sv
// Decode front: accepts payload words, tracks run state and classifies results.
module wrld_front #(
  parameter int TOTAL_WIDTH = wrld_pkg::TOTAL_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wrld_in_if.sink                       in_i,
  input  logic [wrld_pkg::WORD_W-1:0]   eor_code_i,
  input  logic [wrld_pkg::WORD_W-1:0]   lrc_code_i,
  input  wrld_pkg::wrld_qstat_t         q_stat_i,
  output wrld_pkg::wrld_push_t          push_o,
  output wrld_pkg::wrld_front_stat_t    stat_o
);
  import wrld_pkg::*;

  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_LITERAL = 2'd1;
  localparam logic [1:0] MODE_DISCARD = 2'd2;

  logic [1:0]             mode_q, mode_d;
  logic [COUNT_W-1:0]     left_q, left_d;
  logic [TOTAL_WIDTH-1:0] sum_q, sum_d;

  logic                   accept;
  logic [COUNT_W-1:0]     count;
  logic [COUNT_W-1:0]     left_dec;
  logic [TOTAL_WIDTH:0]   sum_ext;
  logic [TOTAL_WIDTH-1:0] sum_sat;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  assign count    = COUNT_W'(in_i.payload_word & MASK15);
  assign left_dec = (left_q == '0) ? '0 : left_q - 1'b1;
  assign sum_ext  = {1'b0, sum_q} + (TOTAL_WIDTH + 1)'(count);
  assign sum_sat  = sum_ext[TOTAL_WIDTH] ? '1 : sum_ext[TOTAL_WIDTH-1:0];

  assign stat_o.in_literal = (mode_q == MODE_LITERAL);
  assign stat_o.left_zero  = (left_q == '0);

  always_comb begin
    mode_d             = mode_q;
    left_d             = left_q;
    sum_d              = sum_q;
    push_o.push        = 1'b0;
    push_o.entry.kind  = KIND_LITERAL;
    push_o.entry.value = RAY_TOTAL_W'(in_i.payload_word);
    if (accept) begin
      unique case (mode_q)
        MODE_LITERAL: begin
          // Words inside a literal run pass through regardless of codes.
          left_d      = left_dec;
          push_o.push = 1'b1;
          if (left_dec == '0) begin
            mode_d = MODE_START;
          end
        end
        MODE_DISCARD: begin
          if (in_i.record_end) begin
            mode_d = MODE_START;
          end
        end
        default: begin
          mode_d = MODE_START;
          priority if (in_i.payload_word == eor_code_i) begin
            push_o.push        = 1'b1;
            push_o.entry.kind  = KIND_RAY;
            push_o.entry.value = RAY_TOTAL_W'(sum_q);
            sum_d              = '0;
          end else if (in_i.payload_word == lrc_code_i && !in_i.record_end) begin
            mode_d = MODE_DISCARD;
          end else begin
            sum_d = sum_sat;
            if (count != '0) begin
              if ((in_i.payload_word & SIGN16) != '0) begin
                left_d = count;
                mode_d = MODE_LITERAL;
              end else begin
                push_o.push        = 1'b1;
                push_o.entry.kind  = KIND_ZERO;
                push_o.entry.value = RAY_TOTAL_W'(count);
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      left_q <= '0;
      sum_q  <= '0;
    end else begin
      mode_q <= mode_d;
      left_q <= left_d;
      sum_q  <= sum_d;
    end
  end

endmodule

FILE: sv/wrld_back.sv
// Back end: takes queued results and drives the registered result channel.
module wrld_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wrld_pkg::wrld_entry_t head_i,
  input  wrld_pkg::wrld_qstat_t q_stat_i,
  output logic                  pop_o,
  wrld_out_if.source            out_o
);
  import wrld_pkg::*;

  logic                   valid_q, valid_d;
  wrld_kind_e             kind_q;
  logic [WORD_W-1:0]      data_q;
  logic [COUNT_W-1:0]     zero_q;
  logic [RAY_TOTAL_W-1:0] total_q;

  assign pop_o = !q_stat_i.empty && (!valid_q || out_o.ready);

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Unused fields of each kind read as zero.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q  <= head_i.kind;
      data_q  <= (head_i.kind == KIND_LITERAL) ? head_i.value[WORD_W-1:0] : '0;
      zero_q  <= (head_i.kind == KIND_ZERO) ? head_i.value[COUNT_W-1:0] : '0;
      total_q <= (head_i.kind == KIND_RAY) ? head_i.value : '0;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.kind       = kind_q;
  assign out_o.data_word  = data_q;
  assign out_o.zero_count = zero_q;
  assign out_o.ray_total  = total_q;

endmodule

FILE: sv/word_run_length_decoder.sv
// Top level of the word run-length decoder with zero runs.
// Throughput: one payload word per cycle, sustained, while the result side keeps up.
// A result passes from the decode front into the result queue and then the output register.
// The decode front, a QUEUE_DEPTH result queue and an output register set this throughput.
// Reset is asynchronous, active low: run state, ray sum, queue and output valid clear,
// and both code registers return to their defaults; no clearing pass is needed.
module word_run_length_decoder #(
  parameter int TOTAL_WIDTH = wrld_pkg::TOTAL_WIDTH_DEF,
  parameter int QUEUE_DEPTH = wrld_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  wrld_in_if.sink                      in_i,
  wrld_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wrld_pkg::PADDR_W-1:0] paddr,
  input  logic [wrld_pkg::PDATA_W-1:0] pwdata,
  output logic [wrld_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import wrld_pkg::*;

`include "word_run_length_decoder_assert.svh"

  // Code registers. Software must write them only while the decoder is idle; the block
  // does not enforce this. The front may use them directly without any shadowing.
  logic [WORD_W-1:0] eor_code_q, eor_code_d;
  logic [WORD_W-1:0] lrc_code_q, lrc_code_d;
  logic              cfg_write;

  wrld_push_t       q_push;
  wrld_qstat_t      q_stat;
  wrld_entry_t      q_head;
  wrld_front_stat_t front_stat;
  logic             pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Register i sits at byte address 4*i, so paddr[2] selects the register.
  always_comb begin
    eor_code_d = eor_code_q;
    lrc_code_d = lrc_code_q;
    if (cfg_write) begin
      unique case (paddr[2])
        REG_EOR_CODE: eor_code_d = pwdata[WORD_W-1:0];
        REG_LRC_CODE: lrc_code_d = pwdata[WORD_W-1:0];
        default:      eor_code_d = eor_code_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_EOR_CODE: prdata = PDATA_W'(eor_code_q);
      REG_LRC_CODE: prdata = PDATA_W'(lrc_code_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eor_code_q <= EOR_CODE_RESET;
      lrc_code_q <= LRC_CODE_RESET;
    end else begin
      eor_code_q <= eor_code_d;
      lrc_code_q <= lrc_code_d;
    end
  end

  // The front takes a word whenever the queue has room, updates the run
  // state and pushes at most one classified result.
  wrld_front #(
    .TOTAL_WIDTH(TOTAL_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .eor_code_i(eor_code_q),
    .lrc_code_i(lrc_code_q),
    .q_stat_i  (q_stat),
    .push_o    (q_push),
    .stat_o    (front_stat)
  );

  // The queue lets the front keep going while a result waits on the output.
  wrld_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .pop_i (pop),
    .head_o(q_head),
    .stat_o(q_stat)
  );

  // The back end expands a queued entry into the result fields and holds
  // them in the output register until the transfer completes.
  wrld_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (q_head),
    .q_stat_i(q_stat),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  // A result must never be pushed into a full queue, or it would be lost.
  `WRLD_ASSERT_IMPL(a_no_push_when_full, clk_i, rst_ni, q_push.push, !q_stat.full, "result pushed into a full queue")

  // Inside a literal run at least one word is always still owed.
  `WRLD_ASSERT_IMPL(a_literal_left_nonzero, clk_i, rst_ni, front_stat.in_literal, !front_stat.left_zero, "literal run with no words left")

  // Every word taken inside a literal run produces a result.
  `WRLD_ASSERT_IMPL(a_literal_word_pushed, clk_i, rst_ni, in_i.valid && in_i.ready && front_stat.in_literal, q_push.push, "literal word dropped")

  // A result taken from the queue shows up on the output in the next cycle.
  `WRLD_ASSERT_NEXT(a_pop_loads_output, clk_i, rst_ni, pop, out_o.valid, "queued result not presented")

endmodule
